/* sv/spp_pkg.sv */
package spp_pkg;

  // Result fields, last member in the lowest bits: placed sits at bit 0
  typedef struct packed {
    logic [15:0] placed_count;
    logic [15:0] piece_tag;
    logic [15:0] placed_height;
    logic [15:0] placed_width;
    logic [15:0] place_y;
    logic [7:0]  place_x;
    logic        placed;
  } spp_result_t;

  // Broadcast command from the sequencer to every column cell
  typedef struct packed {
    logic        clear;   // zero the height
    logic        shift;   // rotate the ring by one column
    logic        raise;   // add lift to the head cell while shifting
    logic [15:0] lift;
  } spp_cell_cmd_t;

  localparam logic [0:0] CFG_SHEET_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_SHEET_HEIGHT = 1'b1;

endpackage

/* sv/spp_cell.sv */
module spp_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  spp_pkg::spp_cell_cmd_t cmd,
  input  logic                   head,
  input  logic [15:0]            h_in,
  output logic [15:0]            h_out
);
  import spp_pkg::*;

  logic [15:0] h_r;
  logic [15:0] h_nxt;

  // Take height from the neighbor, or clear it; the head cell may rise on the way
  always_comb begin
    h_nxt = h_r;
    if (cmd.clear) begin
      h_nxt = '0;
    end else if (cmd.shift) begin
      h_nxt = h_in;
      if (head && cmd.raise) begin
        h_nxt = h_in + cmd.lift;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r <= '0;
    end else begin
      h_r <= h_nxt;
    end
  end

  assign h_out = h_r;

endmodule

/* sv/skyline_piece_placer.sv */
// Skyline bottom-left piece placer.
// Input channel (in_*): one piece per transfer; tuser carries first_piece.
// Result channel (out_*): exactly one result per piece, in order.
// Config channel (cfg_*): index 0 = sheet_width, 1 = sheet_height; write
// only while no piece is in flight.
// The skyline lives in a ring of MAX_COLUMNS column cells. Each included
// piece makes a scan pass around the ring that checks every start column
// for a level run; a placed piece then makes an update pass that raises the
// chosen columns. A rejected piece goes from the scan to the result, and an
// excluded piece goes straight to the result. The block takes a new piece
// only when idle, after the result of the last one has been taken.
// The result waits in an output register; while the receiver stalls, the
// block holds and takes no new piece. Reset zeroes the skyline and count
// and sets the sheet to 256 x 65535.
module skyline_piece_placer #(
  parameter int MAX_COLUMNS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: piece_width[15:0], piece_height[31:16], piece_id[46:32],
  //        include_req[47], rotate[48], zeros[55:49]
  input  logic [55:0] in_tdata,
  input  logic        in_tuser,   // first_piece
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: placed[0], place_x[8:1], place_y[24:9], placed_width[40:25],
  //        placed_height[56:41], piece_tag[72:57], placed_count[88:73],
  //        zeros[95:89]
  output logic [95:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import spp_pkg::*;

  localparam int CW = $clog2(MAX_COLUMNS + 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_PICK = 5'b00100,
    ST_UPD  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t        st_r, st_nxt;
  logic [8:0]    sw_r;
  logic [15:0]   sh_r;
  logic [15:0]   cnt_r;
  logic [15:0]   w_r, h_r, tag_r;
  logic          inc_r;
  logic [CW-1:0] col_r;        // column at head of ring
  logic [CW-1:0] lim_r;        // effective sheet width
  logic [15:0]   run_base_r;
  logic [16:0]   run_len_r;
  logic          found_r;
  logic [16:0]   best_top_r;
  logic [CW-1:0] best_x_r;
  logic [15:0]   best_y_r;
  logic          cand_ok_r;
  spp_result_t   res_r;
  spp_cell_cmd_t cmd;
  logic [15:0]   hh [MAX_COLUMNS];
  logic [15:0]   head_h;
  logic [CW-1:0] lim_c;

  // Column ring, data moving to lower index; cell 0 holds the head column
  for (genvar i = 0; i < MAX_COLUMNS; i++) begin : g_col
    spp_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .cmd  (cmd),
      .head (i == MAX_COLUMNS - 1),
      .h_in (hh[(i + 1) % MAX_COLUMNS]),
      .h_out(hh[i])
    );
  end
  assign head_h = hh[0];

  assign cfg_ready = 1'b1;
  assign in_tready = (st_r == ST_IDLE);
  assign out_tvalid = (st_r == ST_OUT);
  assign out_tdata = {7'd0, res_r};

  // Saturate the sheet width to the ring size
  assign lim_c = (32'(sw_r) > MAX_COLUMNS) ? CW'(MAX_COLUMNS) : CW'(sw_r);

  logic in_xfer;
  assign in_xfer = in_tvalid && in_tready;

  // Scan-pass candidate evaluation at the head column
  logic [16:0]   top_c;
  logic [16:0]   len_c;
  logic          good_c;
  logic [CW-1:0] start_c;
  always_comb begin
    len_c   = (col_r != '0 && head_h == run_base_r) ? run_len_r + 17'd1 : 17'd1;
    start_c = col_r - CW'(w_r) + 1'b1;
    top_c   = {1'b0, head_h} + {1'b0, h_r};
    good_c  = cand_ok_r && (col_r < lim_r) && (len_c >= {1'b0, w_r}) &&
              (top_c <= {1'b0, sh_r}) && (!found_r || top_c < best_top_r);
  end

  // Cell command
  logic in_range_c;
  assign in_range_c = (col_r >= best_x_r) &&
                      ({1'b0, col_r} < {1'b0, best_x_r} + (CW + 1)'(w_r));
  always_comb begin
    cmd       = '0;
    cmd.lift  = h_r;
    cmd.clear = in_xfer && in_tuser;
    cmd.shift = (st_r == ST_SCAN) || (st_r == ST_UPD);
    cmd.raise = (st_r == ST_UPD) && in_range_c;
  end

  logic          last_col;
  assign last_col = (col_r == CW'(MAX_COLUMNS - 1));
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (in_xfer) st_nxt = in_tdata[47] ? ST_SCAN : ST_OUT;
      ST_SCAN: if (last_col) st_nxt = ST_PICK;
      ST_PICK: st_nxt = found_r ? ST_UPD : ST_OUT;
      ST_UPD:  if (last_col) st_nxt = ST_OUT;
      ST_OUT:  if (out_tready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  logic [15:0] w_in, h_in, tag_in;
  always_comb begin
    w_in   = in_tdata[48] ? in_tdata[31:16] : in_tdata[15:0];
    h_in   = in_tdata[48] ? in_tdata[15:0] : in_tdata[31:16];
    tag_in = in_tdata[48] ? (16'd0 - {1'b0, in_tdata[46:32]}) : {1'b0, in_tdata[46:32]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      sw_r    <= 9'd256;
      sh_r    <= 16'hFFFF;
      cnt_r   <= '0;
      col_r   <= '0;
      found_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      // Apply configuration writes
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_SHEET_WIDTH:  sw_r <= cfg_data[8:0];
          CFG_SHEET_HEIGHT: sh_r <= cfg_data;
          default: ;
        endcase
      end
      if (in_xfer) begin
        if (in_tuser) cnt_r <= '0;
        col_r   <= '0;
        found_r <= 1'b0;
      end
      if (st_r == ST_SCAN) begin
        col_r <= last_col ? '0 : col_r + 1'b1;
        if (good_c) begin
          found_r <= 1'b1;
          best_top_r <= top_c;
          best_x_r <= start_c;
          best_y_r <= head_h;
        end
      end
      if (st_r == ST_UPD) begin
        col_r <= last_col ? '0 : col_r + 1'b1;
        if (last_col && cnt_r != 16'hFFFF) cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      w_r        <= w_in;
      h_r        <= h_in;
      tag_r      <= tag_in;
      inc_r      <= in_tdata[47];
      lim_r      <= lim_c;
      cand_ok_r  <= (w_in != 0) && (h_in != 0) && (h_in <= sh_r) &&
                    (32'(w_in) <= 32'(lim_c));
      run_len_r  <= '0;
      run_base_r <= '0;
    end
    if (st_r == ST_SCAN) begin
      run_base_r <= head_h;
      run_len_r  <= len_c;
    end
    if (st_nxt == ST_OUT && st_r != ST_OUT) begin
      res_r.placed        <= inc_r && found_r && (st_r != ST_IDLE);
      res_r.place_x       <= (inc_r && found_r && st_r != ST_IDLE) ? 8'(best_x_r) : '0;
      res_r.place_y       <= (inc_r && found_r && st_r != ST_IDLE) ? best_y_r : '0;
      res_r.placed_width  <= (st_r == ST_IDLE) ? '0 : w_r;
      res_r.placed_height <= (st_r == ST_IDLE) ? '0 : h_r;
      res_r.piece_tag     <= (st_r == ST_IDLE) ? '0 : tag_r;
      res_r.placed_count  <= (st_r == ST_UPD && cnt_r != 16'hFFFF) ? cnt_r + 1'b1 :
                             ((st_r == ST_IDLE && in_tuser) ? '0 : cnt_r);
    end
  end

  // A piece that was placed lies inside the sheet
  a_fit: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_PICK && found_r) |-> (best_top_r <= {1'b0, sh_r}))
    else $error("placed piece exceeds sheet height");
  a_run: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_PICK && found_r) |-> ({1'b0, best_x_r} + (CW + 1)'(w_r) <= {1'b0, lim_r}))
    else $error("placed piece exceeds sheet width");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SCAN || st_r == ST_UPD) |-> !in_tready && !out_tvalid)
    else $error("handshake open during ring pass");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(res_r))
    else $error("result changed while stalled");

endmodule
